[src/mss_pkg.sv]
// mss_pkg: shared types, constants and the character code table for the
// Morse symbol sequencer. No dependencies.
`timescale 1ns / 1ps

package mss_pkg;

    localparam int UNIT_W  = 10;   // unit length register
    localparam int DUR_W   = 13;   // segment duration in ticks
    localparam int UNITS_W = 3;    // segment length in units
    localparam int PAT_W   = 6;    // longest symbol string
    localparam int LEN_W   = 3;    // symbol count
    localparam int CODE_W  = LEN_W + PAT_W;

    localparam logic [UNIT_W-1:0]  UNIT_TICKS_RST = UNIT_W'(100);

    localparam logic [UNITS_W-1:0] UNITS_DOT  = UNITS_W'(1);
    localparam logic [UNITS_W-1:0] UNITS_DASH = UNITS_W'(5);
    localparam logic [UNITS_W-1:0] UNITS_GAP  = UNITS_W'(3);
    localparam logic [UNITS_W-1:0] UNITS_WORD = UNITS_W'(6);

    localparam logic [7:0] CHR_SPACE   = 8'h20;
    localparam logic [7:0] CHR_STOP    = 8'h2E;
    localparam logic [7:0] CHR_QUERY   = 8'h3F;
    localparam logic [7:0] CHR_DIG_0   = 8'h30;
    localparam logic [7:0] CHR_DIG_9   = 8'h39;
    localparam logic [7:0] CHR_UPPER_A = 8'h41;
    localparam logic [7:0] CHR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHR_LOWER_A = 8'h61;
    localparam logic [7:0] CHR_LOWER_Z = 8'h7A;

    // {count, pattern}: pattern is left aligned, first symbol in the top bit,
    // 1 = dash, 0 = dot.
    localparam logic [CODE_W-1:0] ALPHA_CODE [26] = '{
        {3'd2, 6'b010000}, {3'd4, 6'b100000}, {3'd4, 6'b101000}, {3'd3, 6'b100000},
        {3'd1, 6'b000000}, {3'd4, 6'b001000}, {3'd3, 6'b110000}, {3'd4, 6'b000000},
        {3'd2, 6'b000000}, {3'd4, 6'b011100}, {3'd3, 6'b101000}, {3'd4, 6'b010000},
        {3'd2, 6'b110000}, {3'd2, 6'b100000}, {3'd3, 6'b111000}, {3'd4, 6'b011000},
        {3'd4, 6'b110100}, {3'd3, 6'b010000}, {3'd3, 6'b000000}, {3'd1, 6'b100000},
        {3'd3, 6'b001000}, {3'd4, 6'b000100}, {3'd3, 6'b011000}, {3'd4, 6'b100100},
        {3'd4, 6'b101100}, {3'd4, 6'b110000}
    };

    localparam logic [CODE_W-1:0] DIGIT_CODE [10] = '{
        {3'd5, 6'b111110}, {3'd5, 6'b011110}, {3'd5, 6'b001110}, {3'd5, 6'b000110},
        {3'd5, 6'b000010}, {3'd5, 6'b000000}, {3'd5, 6'b100000}, {3'd5, 6'b110000},
        {3'd5, 6'b111000}, {3'd5, 6'b111100}
    };

    localparam logic [CODE_W-1:0] STOP_CODE  = {3'd6, 6'b010101};
    localparam logic [CODE_W-1:0] QUERY_CODE = {3'd6, 6'b001100};

    typedef enum logic [1:0] {
        CLS_NONE,
        CLS_SYM,
        CLS_PUNCT,
        CLS_SPACE
    } t_cls;

    // Microprogram addresses
    typedef enum logic [2:0] {
        ST_FETCH,
        ST_LEAD,
        ST_SYM,
        ST_GAP,
        ST_CEND,
        ST_EXTRA,
        ST_SPACE
    } t_step;

    typedef enum logic [1:0] {
        U_GAP,
        U_WORD,
        U_SYM
    } t_unit;

    typedef enum logic [1:0] {
        L_NEVER,
        L_ALWAYS,
        L_NOT_PUNCT
    } t_last;

    typedef enum logic [2:0] {
        J_NEXT,
        J_ALWAYS,
        J_DISPATCH,
        J_CNT_MORE,
        J_NOT_PUNCT
    } t_jmp;

    typedef struct packed {
        logic  emit;
        logic  level;
        t_unit unit;
        t_last last;
        logic  shift;
        t_jmp  jmp;
        t_step target;
    } t_uop;

    typedef struct packed {
        t_cls             cls;
        logic [LEN_W-1:0] len;
        logic [PAT_W-1:0] pat;
    } t_code;

    // sequencer -> datapath
    typedef struct packed {
        logic load;
        logic step_go;
    } t_ctl;

    // datapath -> sequencer
    typedef struct packed {
        t_cls in_cls;
        logic punct;
        logic cnt_more;
        logic out_free;
    } t_stat;

    function automatic t_code decode_char(input logic [7:0] c);
        t_code             r;
        logic [CODE_W-1:0] e;
        r.cls = CLS_NONE;
        e     = '0;
        if ((c >= CHR_UPPER_A && c <= CHR_UPPER_Z) ||
            (c >= CHR_LOWER_A && c <= CHR_LOWER_Z)) begin
            e     = ALPHA_CODE[5'(c[4:0] - 5'd1)];
            r.cls = CLS_SYM;
        end else if (c >= CHR_DIG_0 && c <= CHR_DIG_9) begin
            e     = DIGIT_CODE[c[3:0]];
            r.cls = CLS_SYM;
        end else if (c == CHR_STOP) begin
            e     = STOP_CODE;
            r.cls = CLS_PUNCT;
        end else if (c == CHR_QUERY) begin
            e     = QUERY_CODE;
            r.cls = CLS_PUNCT;
        end else if (c == CHR_SPACE) begin
            r.cls = CLS_SPACE;
        end
        r.len = e[CODE_W-1:PAT_W];
        r.pat = e[PAT_W-1:0];
        return r;
    endfunction

endpackage

[src/morse_symbol_sequencer.sv]
// The first segment of a character is loaded into the output register by the step
// after its fetch, once the register has room. Throughput: one segment per cycle while
// the output is taken; an unmapped character uses only its fetch step. Segment rate is
// set by the microprogram step counter, one emitting step per cycle unless stalled.
// Reset (i_rst_n low, synchronous): step counter to fetch, output beat dropped,
// unit length back to 100 ticks.
`timescale 1ns / 1ps

// Top level of the Morse symbol sequencer. Depends on mss_pkg, mss_seq, mss_dp.
//
// Structure:
//   mss_seq - step counter plus a small microprogram ROM (mss_rom). Each
//             control word says whether to emit a segment, its level and unit
//             source, how to set the last flag and where to jump next.
//   mss_dp  - unit length register, left-shifting symbol pattern with its
//             count, a 3 x 10 bit duration multiply and the output register.
//
// Microprogram:
//   FETCH  wait for a character beat, dispatch on its class
//   LEAD   3-unit gap ahead of '.' and '?'
//   SYM    dot (1 unit) or dash (5 units) on
//   GAP    3-unit gap after a symbol; back to SYM while symbols remain
//   CEND   3-unit character gap; last unless punctuation
//   EXTRA  trailing 3-unit gap for punctuation, last
//   SPACE  single 6-unit off segment, last
//
// Input is only taken in FETCH; the output register holds one finished beat,
// so the next character can be accepted while the final segment still waits.
// Configuration writes are always accepted.

module morse_symbol_sequencer (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // character channel
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [7:0]                 i_character,
    // segment channel
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic                       o_level,
    output logic [mss_pkg::DUR_W-1:0]  o_duration_ticks,
    output logic                       o_last,
    // configuration write channel
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [mss_pkg::UNIT_W-1:0] i_cfg_unit_ticks
);

    mss_pkg::t_stat w_stat;
    mss_pkg::t_uop  w_uop;
    mss_pkg::t_ctl  w_ctl;

    // register has no side effects on the sequence, so writes never stall
    assign o_cfg_ready = 1'b1;

    mss_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (w_stat),
        .o_in_ready (o_in_ready),
        .o_uop      (w_uop),
        .o_ctl      (w_ctl)
    );

    mss_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctl            (w_ctl),
        .i_uop            (w_uop),
        .i_character      (i_character),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_unit_ticks (i_cfg_unit_ticks),
        .i_out_ready      (i_out_ready),
        .o_stat           (w_stat),
        .o_out_valid      (o_out_valid),
        .o_level          (o_level),
        .o_duration_ticks (o_duration_ticks),
        .o_last           (o_last)
    );

endmodule

[src/mss_rom.sv]
// mss_rom: microprogram store, one control word per step address.
// Depends on mss_pkg.
`timescale 1ns / 1ps

module mss_rom (
    input  mss_pkg::t_step i_step,
    output mss_pkg::t_uop  o_uop
);

    always_comb begin
        unique case (i_step)
            // wait for a character, branch on its class
            mss_pkg::ST_FETCH: o_uop = '{1'b0, 1'b0, mss_pkg::U_GAP, mss_pkg::L_NEVER,
                                         1'b0, mss_pkg::J_DISPATCH, mss_pkg::ST_FETCH};
            mss_pkg::ST_LEAD:  o_uop = '{1'b1, 1'b0, mss_pkg::U_GAP, mss_pkg::L_NEVER,
                                         1'b0, mss_pkg::J_NEXT, mss_pkg::ST_FETCH};
            mss_pkg::ST_SYM:   o_uop = '{1'b1, 1'b1, mss_pkg::U_SYM, mss_pkg::L_NEVER,
                                         1'b0, mss_pkg::J_NEXT, mss_pkg::ST_FETCH};
            // symbol gap, loop back while symbols remain
            mss_pkg::ST_GAP:   o_uop = '{1'b1, 1'b0, mss_pkg::U_GAP, mss_pkg::L_NEVER,
                                         1'b1, mss_pkg::J_CNT_MORE, mss_pkg::ST_SYM};
            mss_pkg::ST_CEND:  o_uop = '{1'b1, 1'b0, mss_pkg::U_GAP, mss_pkg::L_NOT_PUNCT,
                                         1'b0, mss_pkg::J_NOT_PUNCT, mss_pkg::ST_FETCH};
            mss_pkg::ST_EXTRA: o_uop = '{1'b1, 1'b0, mss_pkg::U_GAP, mss_pkg::L_ALWAYS,
                                         1'b0, mss_pkg::J_ALWAYS, mss_pkg::ST_FETCH};
            mss_pkg::ST_SPACE: o_uop = '{1'b1, 1'b0, mss_pkg::U_WORD, mss_pkg::L_ALWAYS,
                                         1'b0, mss_pkg::J_ALWAYS, mss_pkg::ST_FETCH};
            default:           o_uop = '{1'b0, 1'b0, mss_pkg::U_GAP, mss_pkg::L_NEVER,
                                         1'b0, mss_pkg::J_ALWAYS, mss_pkg::ST_FETCH};
        endcase
    end

endmodule

[src/mss_seq.sv]
// mss_seq: step counter with conditional jumps over the microprogram.
// Depends on mss_pkg and mss_rom.
`timescale 1ns / 1ps

module mss_seq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  mss_pkg::t_stat i_stat,
    output logic           o_in_ready,
    output mss_pkg::t_uop  o_uop,
    output mss_pkg::t_ctl  o_ctl
);

    mss_pkg::t_step r_step;
    mss_pkg::t_step n_step;
    mss_pkg::t_step w_jump;
    mss_pkg::t_step w_inc;
    mss_pkg::t_uop  w_uop;
    logic           w_fetch;
    logic           w_go;

    mss_rom u_rom (
        .i_step (r_step),
        .o_uop  (w_uop)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= mss_pkg::ST_FETCH;
        end else begin
            r_step <= n_step;
        end
    end

    always_comb begin
        w_fetch = (r_step == mss_pkg::ST_FETCH);
        w_inc   = mss_pkg::t_step'(r_step + 3'd1);
        // emitting steps wait for room in the output register
        w_go    = w_fetch ? i_in_valid : (!w_uop.emit || i_stat.out_free);
        unique case (w_uop.jmp)
            mss_pkg::J_NEXT:      w_jump = w_inc;
            mss_pkg::J_ALWAYS:    w_jump = w_uop.target;
            mss_pkg::J_DISPATCH: begin
                unique case (i_stat.in_cls)
                    mss_pkg::CLS_SYM:   w_jump = mss_pkg::ST_SYM;
                    mss_pkg::CLS_PUNCT: w_jump = mss_pkg::ST_LEAD;
                    mss_pkg::CLS_SPACE: w_jump = mss_pkg::ST_SPACE;
                    default:            w_jump = mss_pkg::ST_FETCH;
                endcase
            end
            mss_pkg::J_CNT_MORE:  w_jump = i_stat.cnt_more ? w_uop.target : w_inc;
            mss_pkg::J_NOT_PUNCT: w_jump = !i_stat.punct ? w_uop.target : w_inc;
            default:              w_jump = mss_pkg::ST_FETCH;
        endcase
        n_step        = w_go ? w_jump : r_step;
        o_in_ready    = w_fetch;
        o_uop         = w_uop;
        o_ctl.load    = w_fetch && i_in_valid;
        o_ctl.step_go = w_go;
    end

endmodule

[src/mss_dp.sv]
// mss_dp: datapath - unit length register, symbol shifter and count,
// duration multiply and the output register. Depends on mss_pkg.
`timescale 1ns / 1ps

module mss_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  mss_pkg::t_ctl               i_ctl,
    input  mss_pkg::t_uop               i_uop,
    input  logic [7:0]                  i_character,
    input  logic                        i_cfg_valid,
    input  logic [mss_pkg::UNIT_W-1:0]  i_cfg_unit_ticks,
    input  logic                        i_out_ready,
    output mss_pkg::t_stat              o_stat,
    output logic                        o_out_valid,
    output logic                        o_level,
    output logic [mss_pkg::DUR_W-1:0]   o_duration_ticks,
    output logic                        o_last
);

    logic [mss_pkg::UNIT_W-1:0]  r_unit_ticks;
    logic [mss_pkg::PAT_W-1:0]   r_pat;
    logic [mss_pkg::LEN_W-1:0]   r_cnt;
    mss_pkg::t_cls               r_cls;
    logic                        r_out_valid;
    logic                        r_level;
    logic [mss_pkg::DUR_W-1:0]   r_dur;
    logic                        r_last;

    mss_pkg::t_code              w_code;
    logic [mss_pkg::UNITS_W-1:0] w_units;
    logic [mss_pkg::DUR_W-1:0]   w_prod;
    logic                        w_last;
    logic                        w_load_out;

    always_comb begin
        w_code = mss_pkg::decode_char(i_character);
        unique case (i_uop.unit)
            mss_pkg::U_WORD: w_units = mss_pkg::UNITS_WORD;
            mss_pkg::U_SYM:  w_units = r_pat[mss_pkg::PAT_W-1] ? mss_pkg::UNITS_DASH
                                                               : mss_pkg::UNITS_DOT;
            default:         w_units = mss_pkg::UNITS_GAP;
        endcase
        w_prod = mss_pkg::DUR_W'(w_units) * mss_pkg::DUR_W'(r_unit_ticks);
        unique case (i_uop.last)
            mss_pkg::L_ALWAYS:    w_last = 1'b1;
            mss_pkg::L_NOT_PUNCT: w_last = (r_cls != mss_pkg::CLS_PUNCT);
            default:              w_last = 1'b0;
        endcase
        w_load_out = i_ctl.step_go && i_uop.emit;

        o_stat.in_cls   = w_code.cls;
        o_stat.punct    = (r_cls == mss_pkg::CLS_PUNCT);
        o_stat.cnt_more = (r_cnt > mss_pkg::LEN_W'(1));
        o_stat.out_free = !r_out_valid || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit_ticks <= mss_pkg::UNIT_TICKS_RST;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_unit_ticks <= i_cfg_unit_ticks;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_pat <= w_code.pat;
            r_cnt <= w_code.len;
            r_cls <= w_code.cls;
        end else if (i_ctl.step_go && i_uop.shift) begin
            r_pat <= {r_pat[mss_pkg::PAT_W-2:0], 1'b0};
            r_cnt <= r_cnt - mss_pkg::LEN_W'(1);
        end
        if (w_load_out) begin
            r_level <= i_uop.level;
            r_dur   <= w_prod;
            r_last  <= w_last;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_level          = r_level;
    assign o_duration_ticks = r_dur;
    assign o_last           = r_last;

endmodule

[src/mss_checker.sv]
// mss_checker: port-level assertions for morse_symbol_sequencer, bound to
// the top level below. Depends on mss_pkg.
`timescale 1ns / 1ps

module mss_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_ready,
    input logic [7:0]                 i_character,
    input logic                       o_out_valid,
    input logic                       i_out_ready,
    input logic                       o_level,
    input logic [mss_pkg::DUR_W-1:0]  o_duration_ticks,
    input logic                       o_last
);

    // a stalled beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_level) && $stable(o_duration_ticks) && $stable(o_last)))
        else $error("output beat dropped or changed while stalled");

    // every run ends on an off segment
    a_on_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_level) |-> !o_last)
        else $error("on segment flagged as last");

    // accepting a space drops o_in_ready, as the block moves on to emit its word gap
    a_space_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && (i_character == mss_pkg::CHR_SPACE)) |=> !o_in_ready)
        else $error("space accepted without emitting");

    // reset empties the output register
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind morse_symbol_sequencer mss_checker u_mss_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_ready       (o_in_ready),
    .i_character      (i_character),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_level          (o_level),
    .o_duration_ticks (o_duration_ticks),
    .o_last           (o_last)
);
